FILE: rtl/g711_pkg.sv
// g711_pkg: operation codes, scaling and companding constants and the mu-law
// segment table for the g711 companding codec core. No dependencies.
package g711_pkg;

	typedef enum logic [2:0] {
		OP_ALAW_ENC        = 3'd0,
		OP_ULAW_ENC        = 3'd1,
		OP_ALAW_DEC_FULL   = 3'd2,
		OP_ULAW_DEC_FULL   = 3'd3,
		OP_ALAW_DEC_SCALED = 3'd4,
		OP_ULAW_DEC_SCALED = 3'd5
	} op_t;

	localparam int SCALED_BITS = 9;
	localparam int SCALE_SHIFT = 15 - SCALED_BITS;

	localparam logic [7:0]  ALAW_XOR   = 8'h55;
	localparam logic [7:0]  ALAW_POS   = 8'hD5;
	localparam logic [14:0] ULAW_BIAS  = 15'h0084;
	localparam logic [15:0] ULAW_CLIP  = 16'd32635;
	localparam logic [14:0] MAG_MAX    = 15'h7FFF;
	localparam logic [7:0]  ULAW_ZTRAP = 8'h02;
	localparam logic [7:0]  ULAW_FF    = 8'hFF;
	localparam logic [7:0]  ULAW_FFMAP = 8'h7F;

	// lower edge of each mu-law segment
	function automatic logic [14:0] ulaw_seg_base(input logic [2:0] e);
		logic [14:0] b;
		unique case (e)
			3'd0: b = 15'd0;
			3'd1: b = 15'd132;
			3'd2: b = 15'd396;
			3'd3: b = 15'd924;
			3'd4: b = 15'd1980;
			3'd5: b = 15'd4092;
			3'd6: b = 15'd8316;
			3'd7: b = 15'd16764;
		endcase
		return b;
	endfunction

endpackage

FILE: rtl/g711_companding_codec_core.sv
// g711_companding_codec_core: two-stage G.711 A-law / mu-law encoder and decoder.
// Depends on g711_pkg for op codes, scaling and the mu-law segment table.
// A request is captured into the stage-1 registers and its result into code_out and
// linear_out with done. Throughput: one request per cycle, busy is never high.
// Reset (arst_n low, asynchronous) clears the stage valid bits; results are never
// stalled, as the receiver takes each one in the cycle it is shown.
module g711_companding_codec_core
	import g711_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         op,
	input  logic signed [15:0] linear_sample,
	input  logic [7:0]         code_byte,
	output logic               done,
	output logic [7:0]         code_out,
	output logic signed [15:0] linear_out
);

	// segment number from the top seven bits of a 15-bit magnitude
	function automatic logic [2:0] seg_of(input logic [6:0] hi);
		logic [2:0] s;
		s = 3'd0;
		for (int i = 0; i < 7; i++) begin
			if (hi[i]) s = 3'(i + 1);
		end
		return s;
	endfunction

	logic               valid_s1;
	logic [2:0]         op_s1;
	logic signed [15:0] sample_s1;
	logic [7:0]         code_s1;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			op_s1     <= op;
			sample_s1 <= linear_sample;
			code_s1   <= code_byte;
		end
	end

	// magnitude, unsigned; -32768 gives 0x8000
	logic [15:0] abs16;
	assign abs16 = sample_s1[15] ? 16'(-sample_s1) : 16'(sample_s1);

	// a-law encode
	logic [14:0] a_mag;
	logic [2:0]  a_seg;
	logic [3:0]  a_sh;
	logic [14:0] a_shifted;
	logic [7:0]  a_enc;

	assign a_mag     = abs16[15] ? MAG_MAX : abs16[14:0];
	assign a_seg     = seg_of(a_mag[14:8]);
	assign a_sh      = (a_seg == 3'd0) ? 4'd4 : (4'(a_seg) + 4'd3);
	assign a_shifted = a_mag >> a_sh;
	assign a_enc     = {1'b0, a_seg, a_shifted[3:0]} ^ (sample_s1[15] ? ALAW_XOR : ALAW_POS);

	// mu-law encode
	logic [14:0] u_mag;
	logic [14:0] u_biased;
	logic [2:0]  u_exp;
	logic [14:0] u_shifted;
	logic [7:0]  u_raw;
	logic [7:0]  u_enc;

	assign u_mag     = (abs16 > ULAW_CLIP) ? ULAW_CLIP[14:0] : abs16[14:0];
	assign u_biased  = u_mag + ULAW_BIAS;
	assign u_exp     = seg_of(u_biased[14:8]);
	assign u_shifted = u_biased >> (4'(u_exp) + 4'd3);
	assign u_raw     = ~{sample_s1[15], u_exp, u_shifted[3:0]};

	always_comb begin
		priority if (u_raw == 8'h00) begin
			u_enc = ULAW_ZTRAP;
		end else if (u_raw == ULAW_FF) begin
			u_enc = ULAW_FFMAP;
		end else begin
			u_enc = u_raw;
		end
	end

	// a-law decode
	logic [7:0]         a_code;
	logic [14:0]        a_step;
	logic signed [15:0] a_dec;

	assign a_code = code_s1 ^ ALAW_XOR;
	assign a_step = (a_code[6:4] == 3'd0) ? {7'd0, a_code[3:0], 4'd0}
		: (15'({1'b1, a_code[3:0], 4'd0}) << (a_code[6:4] - 3'd1));
	assign a_dec  = a_code[7] ? $signed({1'b0, a_step}) : -$signed({1'b0, a_step});

	// mu-law decode, negative zero falls out as zero
	logic [7:0]         u_code;
	logic [14:0]        u_step;
	logic signed [15:0] u_dec;

	assign u_code = ~code_s1;
	assign u_step = (15'(u_code[3:0]) << (4'(u_code[6:4]) + 4'd3)) + ulaw_seg_base(u_code[6:4]);
	assign u_dec  = u_code[7] ? -$signed({1'b0, u_step}) : $signed({1'b0, u_step});

	logic [7:0]         code_d;
	logic signed [15:0] lin_d;

	always_comb begin
		code_d = 8'd0;
		lin_d  = 16'sd0;
		unique case (op_s1)
			OP_ALAW_ENC:        code_d = a_enc;
			OP_ULAW_ENC:        code_d = u_enc;
			OP_ALAW_DEC_FULL:   lin_d  = a_dec;
			OP_ULAW_DEC_FULL:   lin_d  = u_dec;
			OP_ALAW_DEC_SCALED: lin_d  = a_dec >>> SCALE_SHIFT;
			OP_ULAW_DEC_SCALED: lin_d  = u_dec >>> SCALE_SHIFT;
			default: begin
				code_d = 8'd0;
				lin_d  = 16'sd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			code_out   <= code_d;
			linear_out <= lin_d;
		end
	end

	a_req_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("request did not produce a result two cycles later");

	a_done_has_req: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(valid_s1))
		else $error("result strobe without a request in flight");

	a_one_field: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (code_out == 8'd0) || (linear_out == 16'sd0))
		else $error("both code and linear result non-zero");

	a_enc_no_lin: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && (op_s1 == OP_ALAW_ENC || op_s1 == OP_ULAW_ENC)) |=> (linear_out == 16'sd0))
		else $error("encode request gave a linear value");

endmodule

FILE: bench/g711_companding_codec_core_tb.sv
// g711_companding_codec_core_tb: self-checking bench for the G.711 A-law / mu-law core.
// Depends on g711_pkg (op codes, scaling and companding constants) and the core RTL.
// Encode and decode results are predicted in the bench and checked in arrival order.
module g711_companding_codec_core_tb
	import g711_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam time HALF_PERIOD = 5ns;
	localparam int  CYCLE_LIMIT = 200000;
	localparam int  DRAIN_CYCLES = 4;

	// op encodings the core does not use
	localparam logic [2:0] OP_UNUSED_6 = 3'd6;
	localparam logic [2:0] OP_UNUSED_7 = 3'd7;

	localparam op_t DECODE_OPS [4] = '{OP_ALAW_DEC_FULL, OP_ULAW_DEC_FULL,
		OP_ALAW_DEC_SCALED, OP_ULAW_DEC_SCALED};

	typedef struct {
		logic [7:0]         code;
		logic signed [15:0] linear;
	} codec_result_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [2:0]         op;
	logic signed [15:0] linear_sample;
	logic [7:0]         code_byte;
	logic               done;
	logic [7:0]         code_out;
	logic signed [15:0] linear_out;

	codec_result_t pending_results [$];
	int            error_count = 0;
	int            cycle_count = 0;

	g711_companding_codec_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.op            (op),
		.linear_sample (linear_sample),
		.code_byte     (code_byte),
		.done          (done),
		.code_out      (code_out),
		.linear_out    (linear_out)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// ---------------------------------------------------------------- predictor

	function automatic logic [7:0] alaw_compress(input logic signed [15:0] sample);
		int         mag;
		int         seg;
		int         sh;
		logic [7:0] mask;
		mask = (sample >= 0) ? ALAW_POS : ALAW_XOR;
		mag = (sample >= 0) ? int'(sample) : -int'(sample);
		if (mag > int'(MAG_MAX)) begin
			mag = int'(MAG_MAX);
		end
		seg = 0;
		// segment tops are 0xff, 0x1ff ... 0x7fff
		while (seg < 7 && mag > ((32'h100 << seg) - 1)) begin
			seg++;
		end
		sh = (seg != 0) ? seg + 3 : 4;
		return {1'b0, 3'(seg), 4'(mag >> sh)} ^ mask;
	endfunction

	function automatic logic [7:0] ulaw_compress(input logic signed [15:0] sample);
		int         mag;
		int         top;
		int         seg;
		logic       sign;
		logic [7:0] code;
		sign = (sample < 0);
		mag = sign ? -int'(sample) : int'(sample);
		if (mag > int'(ULAW_CLIP)) begin
			mag = int'(ULAW_CLIP);
		end
		mag += int'(ULAW_BIAS);
		top = (mag >> 7) & 8'hFF;
		seg = 0;
		while (top > 1) begin
			top >>= 1;
			seg++;
		end
		code = ~{sign, 3'(seg), 4'(mag >> (seg + 3))};
		if (code == '0) begin
			code = ULAW_ZTRAP;
		end
		if (code == ULAW_FF) begin
			code = ULAW_FFMAP;
		end
		return code;
	endfunction

	function automatic int alaw_expand(input logic [7:0] code);
		logic [7:0] a;
		int         v;
		a = code ^ ALAW_XOR;
		v = int'(a[3:0]) << 4;
		if (a[6:4] != 3'd0) begin
			v = (v + 32'h100) << (a[6:4] - 1);
		end
		return a[7] ? v : -v;
	endfunction

	function automatic int ulaw_expand(input logic [7:0] code);
		logic [7:0] m;
		int         y;
		m = ~code;
		// segment floors follow bias * (2^seg - 1)
		y = (int'(m[3:0]) << (m[6:4] + 3)) + ((int'(ULAW_BIAS) << m[6:4]) - int'(ULAW_BIAS));
		return m[7] ? -y : y;
	endfunction

	function automatic codec_result_t predict_result(input logic [2:0] req_op,
			input logic signed [15:0] sample, input logic [7:0] code);
		codec_result_t r;
		int            lin;
		r.code = '0;
		lin = 0;
		case (req_op)
			OP_ALAW_ENC:        r.code = alaw_compress(sample);
			OP_ULAW_ENC:        r.code = ulaw_compress(sample);
			OP_ALAW_DEC_FULL:   lin = alaw_expand(code);
			OP_ULAW_DEC_FULL:   lin = ulaw_expand(code);
			OP_ALAW_DEC_SCALED: lin = alaw_expand(code) >>> SCALE_SHIFT;
			OP_ULAW_DEC_SCALED: lin = ulaw_expand(code) >>> SCALE_SHIFT;
			default:            lin = 0;
		endcase
		r.linear = lin[15:0];
		return r;
	endfunction

	// ---------------------------------------------------------------- checker

	// sampled mid-cycle, well clear of the edges where done changes
	always @(negedge clk) begin
		codec_result_t expected;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: code_out %02h, linear_out %0d",
					code_out, linear_out);
				error_count++;
			end else begin
				expected = pending_results.pop_front();
				if (code_out !== expected.code) begin
					$error("code_out: expected %02h, actual %02h", expected.code, code_out);
					error_count++;
				end
				if (linear_out !== expected.linear) begin
					$error("linear_out: expected %0d, actual %0d",
						expected.linear, linear_out);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("g711_companding_codec_core_tb failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------- request driving

	task automatic send_request(input logic [2:0] req_op, input logic signed [15:0] sample,
			input logic [7:0] code);
		bit taken;
		start         <= 1'b1;
		op            <= req_op;
		linear_sample <= sample;
		code_byte     <= code;
		do begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end while (!taken);
		pending_results.push_back(predict_result(req_op, sample, code));
	endtask

	// start held low; the other inputs carry junk the core must ignore
	task automatic idle_burst(input bit allowed);
		int cycles;
		if (allowed && $urandom_range(0, 3) == 0) begin
			cycles = $urandom_range(1, 16);
			start         <= 1'b0;
			op            <= 3'($urandom);
			linear_sample <= 16'($urandom);
			code_byte     <= 8'($urandom);
			repeat (cycles) @(posedge clk);
		end
	endtask

	function automatic logic signed [15:0] random_sample();
		logic signed [15:0] s;
		s = 16'($urandom);
		case ($urandom_range(0, 15))
			0:       s = -16'sd32768;
			1:       s = 16'sd32767;
			2:       s = $urandom_range(0, 1) ? 16'sd32635 : -16'sd32635;
			3:       s = $urandom_range(0, 1) ? 16'sd32636 : -16'sd32636;
			default: s = s >>> $urandom_range(0, 15);
		endcase
		return s;
	endfunction

	function automatic logic [2:0] random_op();
		if ($urandom_range(0, 9) == 0) begin
			return 3'($urandom);
		end
		return 3'($urandom_range(OP_ALAW_ENC, OP_ULAW_DEC_SCALED));
	endfunction

	// ---------------------------------------------------------------- tests

	task automatic test_directed_cases();
		// segment edges, saturation of the most negative sample, zero trap and 0xff remap
		send_request(OP_ALAW_ENC, 16'sd0, 8'($urandom));
		send_request(OP_ALAW_ENC, -16'sd1, 8'($urandom));
		send_request(OP_ALAW_ENC, 16'sd32767, 8'($urandom));
		send_request(OP_ALAW_ENC, -16'sd32768, 8'($urandom));
		send_request(OP_ALAW_ENC, 16'sd255, 8'($urandom));
		send_request(OP_ALAW_ENC, 16'sd256, 8'($urandom));
		send_request(OP_ULAW_ENC, 16'sd0, 8'($urandom));
		send_request(OP_ULAW_ENC, -16'sd32768, 8'($urandom));
		send_request(OP_ULAW_ENC, 16'sd32635, 8'($urandom));
		send_request(OP_ULAW_ENC, 16'sd32636, 8'($urandom));
		send_request(OP_ULAW_ENC, -16'sd32635, 8'($urandom));
		send_request(OP_ULAW_ENC, -16'sd1, 8'($urandom));
		send_request(OP_ALAW_DEC_FULL, 16'($urandom), 8'h00);
		send_request(OP_ALAW_DEC_FULL, 16'($urandom), 8'hFF);
		send_request(OP_ALAW_DEC_FULL, 16'($urandom), 8'hD5);
		send_request(OP_ULAW_DEC_FULL, 16'($urandom), 8'hFF);
		send_request(OP_ULAW_DEC_FULL, 16'($urandom), 8'h7F);
		send_request(OP_ULAW_DEC_FULL, 16'($urandom), 8'h00);
		send_request(OP_ULAW_DEC_FULL, 16'($urandom), 8'h80);
		// negative scaled values round toward minus infinity
		send_request(OP_ALAW_DEC_SCALED, 16'($urandom), 8'h2A);
		send_request(OP_ALAW_DEC_SCALED, 16'($urandom), 8'h54);
		send_request(OP_ULAW_DEC_SCALED, 16'($urandom), 8'h00);
		send_request(OP_ULAW_DEC_SCALED, 16'($urandom), 8'h7E);
		send_request(OP_UNUSED_6, 16'($urandom), 8'($urandom));
		send_request(OP_UNUSED_7, 16'($urandom), 8'($urandom));
	endtask

	task automatic test_every_decode_code();
		for (int code = 0; code < 256; code++) begin
			foreach (DECODE_OPS[k]) begin
				send_request(DECODE_OPS[k], 16'($urandom), 8'(code));
				idle_burst(code[5]);
			end
		end
	endtask

	task automatic test_random_mix();
		bit gaps_on;
		for (int n = 0; n < 220; n++) begin
			if (n % 32 == 0) begin
				gaps_on = ($urandom_range(0, 2) != 0);
			end
			send_request(random_op(), random_sample(), 8'($urandom));
			idle_burst(gaps_on);
		end
	endtask

	task automatic test_back_to_back();
		repeat (80) begin
			send_request(random_op(), random_sample(), 8'($urandom));
		end
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		arst_n        <= 1'b0;
		start         <= 1'b0;
		op            <= OP_ALAW_ENC;
		linear_sample <= '0;
		code_byte     <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_every_decode_code();
		test_random_mix();
		test_back_to_back();

		start <= 1'b0;
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0) begin
			$display("g711_companding_codec_core_tb passed");
		end else begin
			$display("g711_companding_codec_core_tb failed");
		end
		$finish;
	end

endmodule

FILE: sim.f
rtl/g711_pkg.sv
rtl/g711_companding_codec_core.sv
bench/g711_companding_codec_core_tb.sv
